/* rtl/core/rmq_pkg.sv */
`default_nettype none
package rmq_pkg;

   // one input item: the nine matrix elements
   typedef struct packed {
      logic signed [15:0] row0_col0;
      logic signed [15:0] row0_col1;
      logic signed [15:0] row0_col2;
      logic signed [15:0] row1_col0;
      logic signed [15:0] row1_col1;
      logic signed [15:0] row1_col2;
      logic signed [15:0] row2_col0;
      logic signed [15:0] row2_col1;
      logic signed [15:0] row2_col2;
   } req_type;

   // one result item
   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic               degenerate;
   } rsp_type;

   localparam int LANES       = 4;
   localparam int CALC_W      = 34;   // element sums and radicand, signed
   localparam int MAG_W       = 32;   // unnormalized magnitudes
   localparam int NORM_W      = 30;   // normalized magnitudes, top in bit 29
   localparam int NORM_TOP    = NORM_W - 1;
   localparam int SHIFT_W     = 5;
   localparam int SUM_W       = 62;   // sum of squares
   localparam int ROOT_W      = 31;   // integer square root
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // classified item handed from front to back
   typedef struct packed {
      logic [LANES-1:0][MAG_W-1:0] mag;
      logic [LANES-1:0]            neg;
      logic                        degen;
   } cls_type;

endpackage
`default_nettype wire

/* rtl/core/rmq_front.sv */
`default_nettype none
module rmq_front
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = 14
) (
   input  req_type req_data,
   output cls_type cls_data
);

   localparam logic signed [CALC_W-1:0] ONE = CALC_W'(1) << FRAC_BITS;

   logic signed [CALC_W-1:0] m [9];
   logic signed [CALC_W-1:0] trace;
   logic signed [CALC_W-1:0] rad;
   logic signed [CALC_W-1:0] v [LANES];
   logic signed [CALC_W-1:0] absval [LANES];

   always_comb begin
      m[0] = CALC_W'(req_data.row0_col0);
      m[1] = CALC_W'(req_data.row0_col1);
      m[2] = CALC_W'(req_data.row0_col2);
      m[3] = CALC_W'(req_data.row1_col0);
      m[4] = CALC_W'(req_data.row1_col1);
      m[5] = CALC_W'(req_data.row1_col2);
      m[6] = CALC_W'(req_data.row2_col0);
      m[7] = CALC_W'(req_data.row2_col1);
      m[8] = CALC_W'(req_data.row2_col2);
      trace = m[0] + m[4] + m[8];
      // pivot selection on the transposed matrix
      priority if (trace > 0) begin
         rad  = trace + ONE;
         v[0] = rad;
         v[1] = m[7] - m[5];
         v[2] = m[2] - m[6];
         v[3] = m[3] - m[1];
      end else if (m[0] > m[4] && m[0] > m[8]) begin
         rad  = ONE + m[0] - m[4] - m[8];
         v[0] = m[7] - m[5];
         v[1] = rad;
         v[2] = m[1] + m[3];
         v[3] = m[2] + m[6];
      end else if (m[4] > m[8]) begin
         rad  = ONE + m[4] - m[0] - m[8];
         v[0] = m[2] - m[6];
         v[1] = m[1] + m[3];
         v[2] = rad;
         v[3] = m[5] + m[7];
      end else begin
         rad  = ONE + m[8] - m[0] - m[4];
         v[0] = m[3] - m[1];
         v[1] = m[2] + m[6];
         v[2] = m[5] + m[7];
         v[3] = rad;
      end
      for (int c = 0; c < LANES; c++) begin
         cls_data.neg[c] = v[c] < 0;
         absval[c]       = cls_data.neg[c] ? -v[c] : v[c];
         cls_data.mag[c] = absval[c][MAG_W-1:0];
      end
      cls_data.degen = rad <= 0;
   end

endmodule
`default_nettype wire

/* rtl/core/rmq_queue.sv */
`default_nettype none
module rmq_queue
   import rmq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cls_type wdata,
   output logic    full,
   input  logic    pop,
   output cls_type rdata,
   output logic    empty
);

   cls_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;
   logic                push_ok, pop_ok;

   assign full    = cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign empty   = cnt_ff == '0;
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push_ok ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop_ok ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push_ok) - (QPTR_W+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/rmq_back.sv */
`default_nettype none
module rmq_back
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = 14
) (
   input  logic    clock,
   input  logic    reset,
   input  cls_type q_data,
   input  logic    q_empty,
   output logic    q_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int QB = FRAC_BITS + 1;
   localparam int DW = NORM_W + FRAC_BITS + 2;
   localparam int SW = (QB + 2 > 17) ? QB + 2 : 17;
   localparam logic [QB-1:0]        Q_MAX  = QB'(1) << FRAC_BITS;
   localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
   localparam logic signed [SW-1:0] SAT_LO = -(SW'(32768));

   typedef struct packed {
      logic [LANES-1:0][NORM_W-1:0] norm;
      logic [LANES-1:0]             neg;
      logic                         degen;
   } side_type;

   logic adv;
   assign adv   = rsp_empty || rsp_pop;
   assign q_pop = adv && !q_empty;

   // stage 0: leading-one position of the largest magnitude
   logic [MAG_W-1:0]   or_w;
   logic [SHIFT_W-1:0] tb_w;
   logic               s0_valid_ff;
   cls_type            s0_cls_ff;
   logic               s0_rsh_ff, s0_rsh_in;
   logic [SHIFT_W-1:0] s0_lsh_ff, s0_lsh_in;

   always_comb begin
      or_w = '0;
      for (int c = 0; c < LANES; c++) begin
         or_w = or_w | q_data.mag[c];
      end
      tb_w = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (or_w[i]) begin
            tb_w = SHIFT_W'(i);
         end
      end
      s0_rsh_in = tb_w >= SHIFT_W'(NORM_W);
      s0_lsh_in = SHIFT_W'(NORM_TOP) - tb_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= !q_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_cls_ff <= q_data;
         s0_rsh_ff <= s0_rsh_in;
         s0_lsh_ff <= s0_lsh_in;
      end
   end

   // stage 1: normalize
   logic       s1_valid_ff;
   side_type   s1_side_ff, s1_side_in;
   logic [63:0] wide_w [LANES];

   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         wide_w[c] = 64'(s0_cls_ff.mag[c]) << s0_lsh_ff;
         s1_side_in.norm[c] = s0_rsh_ff ? NORM_W'(s0_cls_ff.mag[c] >> 1)
                                        : wide_w[c][NORM_W-1:0];
      end
      s1_side_in.neg   = s0_cls_ff.neg;
      s1_side_in.degen = s0_cls_ff.degen;
   end

   // stage 2: squares
   logic                           s2_valid_ff;
   side_type                       s2_side_ff;
   logic [LANES-1:0][2*NORM_W-1:0] s2_prod_ff, s2_prod_in;

   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         s2_prod_in[c] = (2*NORM_W)'(s1_side_ff.norm[c]) * (2*NORM_W)'(s1_side_ff.norm[c]);
      end
   end

   // stage 3 and 4: sum of squares
   logic                  s3_valid_ff;
   side_type              s3_side_ff;
   logic [2*NORM_W:0]     s3_lo_ff, s3_lo_in, s3_hi_ff, s3_hi_in;
   logic                  s4_valid_ff;
   side_type              s4_side_ff;
   logic [SUM_W-1:0]      s4_n_ff, s4_n_in;

   assign s3_lo_in = (2*NORM_W+1)'(s2_prod_ff[0]) + (2*NORM_W+1)'(s2_prod_ff[1]);
   assign s3_hi_in = (2*NORM_W+1)'(s2_prod_ff[2]) + (2*NORM_W+1)'(s2_prod_ff[3]);
   assign s4_n_in  = SUM_W'(s3_lo_ff) + SUM_W'(s3_hi_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_side_ff <= s1_side_in;
         s2_side_ff <= s1_side_ff;
         s2_prod_ff <= s2_prod_in;
         s3_side_ff <= s2_side_ff;
         s3_lo_ff   <= s3_lo_in;
         s3_hi_ff   <= s3_hi_in;
         s4_side_ff <= s3_side_ff;
         s4_n_ff    <= s4_n_in;
      end
   end

   // square root, one result bit per stage
   logic [ROOT_W-1:0] sq_valid_ff;
   logic [SUM_W-1:0]  sq_rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] sq_root_ff [ROOT_W];
   side_type          sq_side_ff [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      localparam int K = ROOT_W - 1 - i;
      logic [SUM_W-1:0]  rem_w, rem_in;
      logic [ROOT_W-1:0] root_w, root_in;
      side_type          side_w;
      logic              valid_w;
      logic [SUM_W:0]    trial_w;
      logic              take_w;

      if (i == 0) begin : g_head
         assign rem_w   = s4_n_ff;
         assign root_w  = '0;
         assign side_w  = s4_side_ff;
         assign valid_w = s4_valid_ff;
      end else begin : g_body
         assign rem_w   = sq_rem_ff[i-1];
         assign root_w  = sq_root_ff[i-1];
         assign side_w  = sq_side_ff[i-1];
         assign valid_w = sq_valid_ff[i-1];
      end

      assign trial_w = ((SUM_W+1)'(root_w) << (K + 1)) + ((SUM_W+1)'(1) << (2 * K));
      assign take_w  = {1'b0, rem_w} >= trial_w;
      assign rem_in  = take_w ? rem_w - trial_w[SUM_W-1:0] : rem_w;
      assign root_in = take_w ? root_w | (ROOT_W'(1) << K) : root_w;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[i] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[i] <= valid_w;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[i]  <= rem_in;
            sq_root_ff[i] <= root_in;
            sq_side_ff[i] <= side_w;
         end
      end
   end

   // divide setup: rounded dividend
   logic                     dv_valid_ff;
   logic [LANES-1:0][DW-1:0] dv_rem_ff, dv_rem_in;
   logic [ROOT_W-1:0]        dv_div_ff;
   logic [LANES-1:0]         dv_neg_ff;
   logic                     dv_degen_ff;

   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         dv_rem_in[c] = (DW'(sq_side_ff[ROOT_W-1].norm[c]) << FRAC_BITS)
                      + DW'(sq_root_ff[ROOT_W-1] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff <= 1'b0;
      end else if (adv) begin
         dv_valid_ff <= sq_valid_ff[ROOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff   <= dv_rem_in;
         dv_div_ff   <= sq_root_ff[ROOT_W-1];
         dv_neg_ff   <= sq_side_ff[ROOT_W-1].neg;
         dv_degen_ff <= sq_side_ff[ROOT_W-1].degen;
      end
   end

   // restoring divide, one quotient bit per stage on all four lanes
   logic [QB-1:0]            dq_valid_ff;
   logic [LANES-1:0][DW-1:0] dq_rem_ff   [QB];
   logic [LANES-1:0][QB-1:0] dq_quo_ff   [QB];
   logic [ROOT_W-1:0]        dq_div_ff   [QB];
   logic [LANES-1:0]         dq_neg_ff   [QB];
   logic [QB-1:0]            dq_degen_ff;

   for (genvar j = 0; j < QB; j++) begin : g_div
      localparam int K = FRAC_BITS - j;
      logic [LANES-1:0][DW-1:0] rem_w, rem_in;
      logic [LANES-1:0][QB-1:0] quo_w, quo_in;
      logic [ROOT_W-1:0]        div_w;
      logic [LANES-1:0]         neg_w;
      logic                     degen_w;
      logic                     valid_w;
      logic [DW-1:0]            shifted_w;

      if (j == 0) begin : g_head
         assign rem_w   = dv_rem_ff;
         assign quo_w   = '0;
         assign div_w   = dv_div_ff;
         assign neg_w   = dv_neg_ff;
         assign degen_w = dv_degen_ff;
         assign valid_w = dv_valid_ff;
      end else begin : g_body
         assign rem_w   = dq_rem_ff[j-1];
         assign quo_w   = dq_quo_ff[j-1];
         assign div_w   = dq_div_ff[j-1];
         assign neg_w   = dq_neg_ff[j-1];
         assign degen_w = dq_degen_ff[j-1];
         assign valid_w = dq_valid_ff[j-1];
      end

      assign shifted_w = DW'(div_w) << K;

      always_comb begin
         for (int c = 0; c < LANES; c++) begin
            if (rem_w[c] >= shifted_w) begin
               rem_in[c] = rem_w[c] - shifted_w;
               quo_in[c] = quo_w[c] | (QB'(1) << K);
            end else begin
               rem_in[c] = rem_w[c];
               quo_in[c] = quo_w[c];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dq_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            dq_valid_ff[j] <= valid_w;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dq_rem_ff[j]   <= rem_in;
            dq_quo_ff[j]   <= quo_in;
            dq_div_ff[j]   <= div_w;
            dq_neg_ff[j]   <= neg_w;
            dq_degen_ff[j] <= degen_w;
         end
      end
   end

   // output register: clamp, sign, saturate, zero when degenerate
   logic                   out_valid_ff;
   rsp_type                out_ff, out_in;
   logic [QB-1:0]          qc_w [LANES];
   logic signed [SW-1:0]   sv_w [LANES];
   logic signed [15:0]     comp_w [LANES];
   logic                   degen_w;

   always_comb begin
      degen_w = dq_degen_ff[QB-1];
      for (int c = 0; c < LANES; c++) begin
         qc_w[c] = (dq_quo_ff[QB-1][c] > Q_MAX) ? Q_MAX : dq_quo_ff[QB-1][c];
         sv_w[c] = dq_neg_ff[QB-1][c] ? -$signed(SW'(qc_w[c])) : $signed(SW'(qc_w[c]));
         if (sv_w[c] > SAT_HI) begin
            sv_w[c] = SAT_HI;
         end else if (sv_w[c] < SAT_LO) begin
            sv_w[c] = SAT_LO;
         end
         comp_w[c] = degen_w ? 16'sd0 : sv_w[c][15:0];
      end
      out_in.quat_w     = comp_w[0];
      out_in.quat_x     = comp_w[1];
      out_in.quat_y     = comp_w[2];
      out_in.quat_z     = comp_w[3];
      out_in.degenerate = degen_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dq_valid_ff[QB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

/* rtl/core/rotation_matrix_to_quaternion_top.sv */
// pipeline: 5 normalize/square/sum stages, 31 square-root stages, FRAC_BITS + 2 divide
//   stages and one output register from input transfer to result on the rsp ports
// throughput: one item per cycle while results are popped every cycle
// reset: synchronous, active high; empties the input queue and the pipeline
`default_nettype none
module rotation_matrix_to_quaternion_top
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = 14
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   // front: transpose view, trace test, pivot branch, signed magnitudes
   cls_type cls_w;
   cls_type q_data;
   logic    q_empty;
   logic    q_pop;

   rmq_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .req_data (req_data),
      .cls_data (cls_w)
   );

   // short queue decouples input transfers from back-end stalls
   rmq_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (cls_w),
      .full  (req_full),
      .pop   (q_pop),
      .rdata (q_data),
      .empty (q_empty)
   );

   // back: normalize, sum of squares, square root, four-lane divide;
   // the whole pipeline holds only when the output register is full and not popped
   rmq_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_data),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* rtl/core/rmq_checker.sv */
`default_nettype none
module rmq_checker
   import rmq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // after reset nothing is pending and the queue takes items
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("not empty after reset");

   // a degenerate result carries zero components
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.degenerate |->
         rsp_data.quat_w == 16'sd0 && rsp_data.quat_x == 16'sd0 &&
         rsp_data.quat_y == 16'sd0 && rsp_data.quat_z == 16'sd0)
      else $error("degenerate result with nonzero components");

   // a unit quaternion always has a nonzero component
   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.degenerate |->
         (rsp_data.quat_w | rsp_data.quat_x | rsp_data.quat_y | rsp_data.quat_z) != 16'sd0)
      else $error("all-zero result not flagged degenerate");

   // a waiting result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("result changed before transfer");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (.*);
`default_nettype wire
